>>> sv/gtg_pkg.sv
// Shared constants, register index codes and the arctangent table
// for the go-to-goal controller. No dependencies.
package gtg_pkg;

   localparam int CORDIC_STEPS_DEFAULT = 14;
   localparam int TABLE_LEN = 24;
   localparam int CW = 36;

   localparam logic signed [CW-1:0] PI_Q30       = 36'sd3373259426;
   localparam logic signed [CW-1:0] TWO_PI_Q30   = 36'sd6746518852;
   localparam logic signed [CW-1:0] HALF_PI_Q30  = 36'sd1686629713;
   localparam logic signed [CW-1:0] INV_GAIN_Q30 = 36'sd652032874;

   localparam logic signed [31:0] OUT_MAX = 32'sd8388607;
   localparam logic signed [31:0] OUT_MIN = -32'sd8388608;

   typedef enum logic [2:0] {
      CSR_TARGET_X     = 3'd0,
      CSR_TARGET_Y     = 3'd1,
      CSR_GAIN_LIN     = 3'd2,
      CSR_GAIN_ANG     = 3'd3,
      CSR_LIN_TOL      = 3'd4,
      CSR_ANG_TOL      = 3'd5
   } csr_index_type;

   function automatic logic signed [CW-1:0] atan_q30(input int idx);
      logic signed [CW-1:0] v;
      case (idx)
         0:  v = 36'sd843314857;
         1:  v = 36'sd497837829;
         2:  v = 36'sd263043837;
         3:  v = 36'sd133525159;
         4:  v = 36'sd67021687;
         5:  v = 36'sd33543516;
         6:  v = 36'sd16775851;
         7:  v = 36'sd8388437;
         8:  v = 36'sd4194283;
         9:  v = 36'sd2097149;
         10: v = 36'sd1048576;
         11: v = 36'sd524288;
         12: v = 36'sd262144;
         13: v = 36'sd131072;
         14: v = 36'sd65536;
         15: v = 36'sd32768;
         16: v = 36'sd16384;
         17: v = 36'sd8192;
         18: v = 36'sd4096;
         19: v = 36'sd2048;
         20: v = 36'sd1024;
         21: v = 36'sd512;
         22: v = 36'sd256;
         23: v = 36'sd128;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

>>> sv/go_to_goal_p_controller.sv
// Go-to-goal proportional controller: pipelined CORDIC vectoring for bearing and
// distance, CORDIC rotation for cos of the angular error, gain scaling.
// Depends on gtg_pkg.
// Throughput: one transaction per cycle; busy is tied low and there is no ready
// input, so busy never rises and the receiver cannot stall.
// Reset (synchronous) clears all valid bits and loads the register defaults.
module go_to_goal_p_controller #(
   parameter int CORDIC_STEPS = gtg_pkg::CORDIC_STEPS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [15:0] req_pos_x,
   input  logic signed [15:0] req_pos_y,
   input  logic signed [15:0] req_heading,
   output logic               rsp_valid,
   output logic signed [23:0] rsp_linear_command,
   output logic signed [23:0] rsp_angular_command,
   output logic               rsp_arrived,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wdata
);

   localparam int CW = gtg_pkg::CW;
   localparam int NS = (CORDIC_STEPS > gtg_pkg::TABLE_LEN) ? gtg_pkg::TABLE_LEN :
                       (CORDIC_STEPS < 1) ? 1 : CORDIC_STEPS;

   // configuration registers
   logic signed [15:0] target_x_ff, target_y_ff;
   logic [11:0]        gain_lin_ff, gain_ang_ff;
   logic [15:0]        lin_tol_ff, ang_tol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_x_ff <= '0;
         target_y_ff <= '0;
         gain_lin_ff <= 12'd256;
         gain_ang_ff <= 12'd1536;
         lin_tol_ff  <= 16'd3;
         ang_tol_ff  <= 16'd1;
      end else if (csr_we) begin
         unique case (csr_index)
            gtg_pkg::CSR_TARGET_X: target_x_ff <= csr_wdata;
            gtg_pkg::CSR_TARGET_Y: target_y_ff <= csr_wdata;
            gtg_pkg::CSR_GAIN_LIN: gain_lin_ff <= csr_wdata[11:0];
            gtg_pkg::CSR_GAIN_ANG: gain_ang_ff <= csr_wdata[11:0];
            gtg_pkg::CSR_LIN_TOL:  lin_tol_ff  <= csr_wdata;
            gtg_pkg::CSR_ANG_TOL:  ang_tol_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;
   logic accept;
   assign accept = start & ~busy;

   // ---------------- vectoring chain ----------------
   logic                 vv_ff [0:NS];
   logic signed [CW-1:0] vx_ff [0:NS];
   logic signed [CW-1:0] vy_ff [0:NS];
   logic signed [CW-1:0] vz_ff [0:NS];
   logic                 vnz_ff [0:NS];
   logic signed [15:0]   vh_ff [0:NS];

   logic signed [16:0]   dx_in, dy_in;
   logic signed [CW-1:0] x0_in, y0_in, z0_in;

   always_comb begin
      dx_in = 17'(target_x_ff) - 17'(req_pos_x);
      dy_in = 17'(target_y_ff) - 17'(req_pos_y);
      x0_in = CW'(dx_in) <<< 14;
      y0_in = CW'(dy_in) <<< 14;
      z0_in = '0;
      if (x0_in < 0) begin
         z0_in = (y0_in >= 0) ? gtg_pkg::PI_Q30 : -gtg_pkg::PI_Q30;
         x0_in = -x0_in;
         y0_in = -y0_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) vv_ff[0] <= 1'b0;
      else       vv_ff[0] <= accept;
      vx_ff[0]  <= x0_in;
      vy_ff[0]  <= y0_in;
      vz_ff[0]  <= z0_in;
      vnz_ff[0] <= (dx_in != 0) || (dy_in != 0);
      vh_ff[0]  <= req_heading;
   end

   for (genvar i = 0; i < NS; i++) begin : g_vec
      logic signed [CW-1:0] x_in, y_in, z_in;
      always_comb begin
         if (vy_ff[i] < 0) begin
            x_in = vx_ff[i] - (vy_ff[i] >>> i);
            y_in = vy_ff[i] + (vx_ff[i] >>> i);
            z_in = vz_ff[i] - gtg_pkg::atan_q30(i);
         end else begin
            x_in = vx_ff[i] + (vy_ff[i] >>> i);
            y_in = vy_ff[i] - (vx_ff[i] >>> i);
            z_in = vz_ff[i] + gtg_pkg::atan_q30(i);
         end
      end
      always_ff @(posedge clock) begin
         if (reset) vv_ff[i+1] <= 1'b0;
         else       vv_ff[i+1] <= vv_ff[i];
         vx_ff[i+1]  <= x_in;
         vy_ff[i+1]  <= y_in;
         vz_ff[i+1]  <= z_in;
         vnz_ff[i+1] <= vnz_ff[i];
         vh_ff[i+1]  <= vh_ff[i];
      end
   end

   // ---------------- bearing, error, distance ----------------
   logic                 bv_ff;
   logic signed [17:0]   beang_ff;
   logic signed [32:0]   br_ff;
   logic signed [CW-1:0] mag_in, bz_in;
   logic signed [17:0]   bear_in;
   logic signed [2*CW-1:0] rprod_in;

   always_comb begin
      mag_in   = vnz_ff[NS] ? vx_ff[NS] : '0;
      bz_in    = (vz_ff[NS] + CW'(36'sd131072)) >>> 18;
      bear_in  = vnz_ff[NS] ? bz_in[17:0] : '0;
      rprod_in = (2*CW)'(mag_in) * (2*CW)'(gtg_pkg::INV_GAIN_Q30);
   end

   always_ff @(posedge clock) begin
      if (reset) bv_ff <= 1'b0;
      else       bv_ff <= vv_ff[NS];
      beang_ff <= bear_in - 18'(vh_ff[NS]);
      br_ff    <= rprod_in[62:30];
   end

   // ---------------- angle reduction (two wrap steps, then fold) ----------------
   logic                 wv_ff [0:2];
   logic signed [CW-1:0] we_ff [0:2];
   logic signed [17:0]   weang_ff [0:2];
   logic signed [32:0]   wr_ff [0:2];

   always_ff @(posedge clock) begin
      if (reset) wv_ff[0] <= 1'b0;
      else       wv_ff[0] <= bv_ff;
      we_ff[0]    <= CW'(beang_ff) <<< 18;
      weang_ff[0] <= beang_ff;
      wr_ff[0]    <= br_ff;
   end

   for (genvar k = 0; k < 2; k++) begin : g_wrap
      logic signed [CW-1:0] e_in;
      always_comb begin
         if (we_ff[k] > gtg_pkg::PI_Q30)       e_in = we_ff[k] - gtg_pkg::TWO_PI_Q30;
         else if (we_ff[k] < -gtg_pkg::PI_Q30) e_in = we_ff[k] + gtg_pkg::TWO_PI_Q30;
         else                                  e_in = we_ff[k];
      end
      always_ff @(posedge clock) begin
         if (reset) wv_ff[k+1] <= 1'b0;
         else       wv_ff[k+1] <= wv_ff[k];
         we_ff[k+1]    <= e_in;
         weang_ff[k+1] <= weang_ff[k];
         wr_ff[k+1]    <= wr_ff[k];
      end
   end

   // ---------------- rotation chain for cos ----------------
   logic                 cv_ff [0:NS];
   logic signed [CW-1:0] cx_ff [0:NS];
   logic signed [CW-1:0] cy_ff [0:NS];
   logic signed [CW-1:0] ce_ff [0:NS];
   logic                 cneg_ff [0:NS];
   logic signed [17:0]   ceang_ff [0:NS];
   logic signed [32:0]   cr_ff [0:NS];

   logic signed [CW-1:0] fe_in;
   logic                 fneg_in;
   always_comb begin
      fe_in   = we_ff[2];
      fneg_in = 1'b0;
      if (we_ff[2] > gtg_pkg::HALF_PI_Q30) begin
         fe_in   = we_ff[2] - gtg_pkg::PI_Q30;
         fneg_in = 1'b1;
      end else if (we_ff[2] < -gtg_pkg::HALF_PI_Q30) begin
         fe_in   = we_ff[2] + gtg_pkg::PI_Q30;
         fneg_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cv_ff[0] <= 1'b0;
      else       cv_ff[0] <= wv_ff[2];
      cx_ff[0]    <= gtg_pkg::INV_GAIN_Q30;
      cy_ff[0]    <= '0;
      ce_ff[0]    <= fe_in;
      cneg_ff[0]  <= fneg_in;
      ceang_ff[0] <= weang_ff[2];
      cr_ff[0]    <= wr_ff[2];
   end

   for (genvar i = 0; i < NS; i++) begin : g_rot
      logic signed [CW-1:0] x_in, y_in, e_in;
      always_comb begin
         if (ce_ff[i] >= 0) begin
            x_in = cx_ff[i] - (cy_ff[i] >>> i);
            y_in = cy_ff[i] + (cx_ff[i] >>> i);
            e_in = ce_ff[i] - gtg_pkg::atan_q30(i);
         end else begin
            x_in = cx_ff[i] + (cy_ff[i] >>> i);
            y_in = cy_ff[i] - (cx_ff[i] >>> i);
            e_in = ce_ff[i] + gtg_pkg::atan_q30(i);
         end
      end
      always_ff @(posedge clock) begin
         if (reset) cv_ff[i+1] <= 1'b0;
         else       cv_ff[i+1] <= cv_ff[i];
         cx_ff[i+1]    <= x_in;
         cy_ff[i+1]    <= y_in;
         ce_ff[i+1]    <= e_in;
         cneg_ff[i+1]  <= cneg_ff[i];
         ceang_ff[i+1] <= ceang_ff[i];
         cr_ff[i+1]    <= cr_ff[i];
      end
   end

   // ---------------- linear error ----------------
   logic               mv_ff, mneg_ff;
   logic signed [69:0] mp_ff;
   logic signed [17:0] meang_ff;

   always_ff @(posedge clock) begin
      if (reset) mv_ff <= 1'b0;
      else       mv_ff <= cv_ff[NS];
      mp_ff    <= 70'(cr_ff[NS]) * 70'(cx_ff[NS]);
      mneg_ff  <= cneg_ff[NS];
      meang_ff <= ceang_ff[NS];
   end

   logic               lv_ff;
   logic signed [17:0] lelin_ff, leang_ff;
   logic signed [69:0] lp_in, lr_in;

   always_comb begin
      lp_in = mneg_ff ? -mp_ff : mp_ff;
      lr_in = (lp_in + (70'sd1 <<< 43)) >>> 44;
   end

   always_ff @(posedge clock) begin
      if (reset) lv_ff <= 1'b0;
      else       lv_ff <= mv_ff;
      lelin_ff <= lr_in[17:0];
      leang_ff <= meang_ff;
   end

   // ---------------- commands and arrival ----------------
   logic signed [31:0] lc_in, ac_in;
   logic signed [18:0] abs_l_in, abs_a_in;
   logic signed [23:0] lcs_in, acs_in;

   always_comb begin
      lc_in = (32'(signed'({1'b0, gain_lin_ff})) * 32'(lelin_ff) + 32'sd128) >>> 8;
      ac_in = (32'(signed'({1'b0, gain_ang_ff})) * 32'(leang_ff) + 32'sd128) >>> 8;
      if (lc_in > gtg_pkg::OUT_MAX)      lcs_in = gtg_pkg::OUT_MAX[23:0];
      else if (lc_in < gtg_pkg::OUT_MIN) lcs_in = gtg_pkg::OUT_MIN[23:0];
      else                               lcs_in = lc_in[23:0];
      if (ac_in > gtg_pkg::OUT_MAX)      acs_in = gtg_pkg::OUT_MAX[23:0];
      else if (ac_in < gtg_pkg::OUT_MIN) acs_in = gtg_pkg::OUT_MIN[23:0];
      else                               acs_in = ac_in[23:0];
      abs_l_in = (lelin_ff < 0) ? -19'(lelin_ff) : 19'(lelin_ff);
      abs_a_in = (leang_ff < 0) ? -19'(leang_ff) : 19'(leang_ff);
   end

   logic               ov_ff, oarr_ff;
   logic signed [23:0] olc_ff, oac_ff;

   always_ff @(posedge clock) begin
      if (reset) ov_ff <= 1'b0;
      else       ov_ff <= lv_ff;
      olc_ff  <= lcs_in;
      oac_ff  <= acs_in;
      oarr_ff <= (abs_l_in <= signed'({3'b000, lin_tol_ff})) &&
                 (abs_a_in <= signed'({3'b000, ang_tol_ff}));
   end

   assign rsp_valid           = ov_ff;
   assign rsp_linear_command  = olc_ff;
   assign rsp_angular_command = oac_ff;
   assign rsp_arrived         = oarr_ff;

endmodule

>>> test/tb_go_to_goal_p_controller.sv
// Self-checking testbench for go_to_goal_p_controller: drives pose transactions and
// register writes, predicts each command with an in-bench fixed-point CORDIC model.
// Depends on gtg_pkg and the go_to_goal_p_controller RTL.
module tb_go_to_goal_p_controller;

   localparam int STEPS = gtg_pkg::CORDIC_STEPS_DEFAULT;
   localparam int LATENCY = 2 * STEPS + 9;
   localparam longint PI_L = 64'sd3373259426;
   localparam longint TWO_PI_L = 64'sd6746518852;
   localparam longint HALF_PI_L = 64'sd1686629713;
   localparam longint INV_K = 64'sd652032874;
   localparam longint SAT_HI = 64'sd8388607;
   localparam longint SAT_LO = -64'sd8388608;
   localparam longint ATAN_TBL [0:STEPS-1] = '{
      843314857, 497837829, 263043837, 133525159, 67021687, 33543516, 16775851,
      8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072};

   typedef struct {
      logic signed [23:0] lin;
      logic signed [23:0] ang;
      logic               arrived;
   } command_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic signed [15:0] req_pos_x = '0;
   logic signed [15:0] req_pos_y = '0;
   logic signed [15:0] req_heading = '0;
   logic               rsp_valid;
   logic signed [23:0] rsp_linear_command;
   logic signed [23:0] rsp_angular_command;
   logic               rsp_arrived;
   logic               csr_we = 1'b0;
   logic [2:0]         csr_index = '0;
   logic [15:0]        csr_wdata = '0;

   logic signed [15:0] goal_x, goal_y;
   logic [11:0]        k_lin, k_ang;
   logic [15:0]        tol_lin, tol_ang;

   command_type command_q[$];
   int       n_accepted = 0;
   int       n_checked = 0;
   int       n_arrived = 0;
   int       n_errors = 0;

   go_to_goal_p_controller u_top (.*);

   always #5 clock = ~clock;

   function automatic longint sat24(longint v);
      if (v > SAT_HI) return SAT_HI;
      if (v < SAT_LO) return SAT_LO;
      return v;
   endfunction

   function automatic command_type predict_command(logic signed [15:0] px,
                                                   logic signed [15:0] py,
                                                   logic signed [15:0] hd);
      longint dx, dy, bearing, mag, r, c, elin, eang, x, y, z, nx, e;
      bit neg;
      command_type cmd;
      dx = longint'(goal_x) - longint'(px);
      dy = longint'(goal_y) - longint'(py);
      bearing = 0;
      mag = 0;
      if (dx != 0 || dy != 0) begin
         x = dx * 16384;
         y = dy * 16384;
         z = 0;
         if (x < 0) begin
            z = (y >= 0) ? PI_L : -PI_L;
            x = -x;
            y = -y;
         end
         for (int i = 0; i < STEPS; i++) begin
            if (y < 0) begin
               nx = x - (y >>> i);
               y = y + (x >>> i);
               z -= ATAN_TBL[i];
            end else begin
               nx = x + (y >>> i);
               y = y - (x >>> i);
               z += ATAN_TBL[i];
            end
            x = nx;
         end
         mag = x;
         bearing = (z + (64'sd1 <<< 17)) >>> 18;
      end
      eang = bearing - longint'(hd);
      r = (mag * INV_K) >>> 30;
      e = eang * 262144;
      while (e > PI_L) e -= TWO_PI_L;
      while (e < -PI_L) e += TWO_PI_L;
      neg = 1'b0;
      if (e > HALF_PI_L) begin
         e -= PI_L;
         neg = 1'b1;
      end else if (e < -HALF_PI_L) begin
         e += PI_L;
         neg = 1'b1;
      end
      x = INV_K;
      y = 0;
      for (int i = 0; i < STEPS; i++) begin
         if (e >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            e -= ATAN_TBL[i];
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            e += ATAN_TBL[i];
         end
         x = nx;
      end
      c = neg ? -x : x;
      elin = (r * c + (64'sd1 <<< 43)) >>> 44;
      cmd.lin = 24'(sat24((longint'(k_lin) * elin + 128) >>> 8));
      cmd.ang = 24'(sat24((longint'(k_ang) * eang + 128) >>> 8));
      cmd.arrived = ((elin < 0 ? -elin : elin) <= longint'(tol_lin)) &&
                    ((eang < 0 ? -eang : eang) <= longint'(tol_ang));
      return cmd;
   endfunction

   always @(posedge clock) begin
      command_type exp_cmd;
      if (!reset) begin
         if (start && !busy) begin
            command_q.push_back(predict_command(req_pos_x, req_pos_y, req_heading));
            n_accepted++;
         end
         if (rsp_valid) begin
            if (command_q.size() == 0) begin
               $error("unexpected result transaction");
               n_errors++;
            end else begin
               exp_cmd = command_q.pop_front();
               n_checked++;
               if (exp_cmd.arrived) n_arrived++;
               if (rsp_linear_command !== exp_cmd.lin) begin
                  $error("linear_command: expected %0d, got %0d", exp_cmd.lin,
                         rsp_linear_command);
                  n_errors++;
               end
               if (rsp_angular_command !== exp_cmd.ang) begin
                  $error("angular_command: expected %0d, got %0d", exp_cmd.ang,
                         rsp_angular_command);
                  n_errors++;
               end
               if (rsp_arrived !== exp_cmd.arrived) begin
                  $error("arrived: expected %0d, got %0d", exp_cmd.arrived, rsp_arrived);
                  n_errors++;
               end
            end
         end
      end
   end

   // called in the rising-edge time step; returns in the step of acceptance, or after an idle gap when one is drawn
   task automatic send_pose(logic signed [15:0] px, logic signed [15:0] py,
                            logic signed [15:0] hd, int idle_pct);
      int n_prior;
      n_prior = n_accepted;
      req_pos_x <= px;
      req_pos_y <= py;
      req_heading <= hd;
      start <= 1'b1;
      wait (n_accepted != n_prior);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      wait (command_q.size() == 0);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   // leaves csr_we high; the caller drops it after the last write
   task automatic write_csr(gtg_pkg::csr_index_type idx, logic [15:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         gtg_pkg::CSR_TARGET_X: goal_x = data;
         gtg_pkg::CSR_TARGET_Y: goal_y = data;
         gtg_pkg::CSR_GAIN_LIN: k_lin = data[11:0];
         gtg_pkg::CSR_GAIN_ANG: k_ang = data[11:0];
         gtg_pkg::CSR_LIN_TOL:  tol_lin = data;
         gtg_pkg::CSR_ANG_TOL:  tol_ang = data;
         default: ;
      endcase
   endtask

   task automatic write_all(logic [15:0] tx, logic [15:0] ty, logic [15:0] gl,
                            logic [15:0] ga, logic [15:0] tl, logic [15:0] ta);
      drain();
      write_csr(gtg_pkg::CSR_TARGET_X, tx);
      write_csr(gtg_pkg::CSR_TARGET_Y, ty);
      write_csr(gtg_pkg::CSR_GAIN_LIN, gl);
      write_csr(gtg_pkg::CSR_GAIN_ANG, ga);
      write_csr(gtg_pkg::CSR_LIN_TOL, tl);
      write_csr(gtg_pkg::CSR_ANG_TOL, ta);
      csr_we <= 1'b0;
   endtask

   task automatic test_directed();
      // defaults: goal at origin
      send_pose(16'sd0, 16'sd0, 16'sd0, 0);
      send_pose(16'sd0, 16'sd0, 16'sh7fff, 0);
      send_pose(16'sd0, 16'sd0, -16'sd32768, 0);
      send_pose(16'sd256, 16'sd0, 16'sd0, 0);
      send_pose(16'sd256, -16'sd1, 16'sd0, 0);
      send_pose(16'sd256, 16'sd1, 16'sd0, 0);
      send_pose(-16'sd256, 16'sd256, 16'sd12868, 0);
      send_pose(16'sh7fff, 16'sh7fff, -16'sd32768, 0);
      send_pose(-16'sd32768, -16'sd32768, 16'sh7fff, 0);
      send_pose(16'sh7fff, -16'sd32768, 16'sd0, 0);
      send_pose(-16'sd32768, 16'sh7fff, 16'sd0, 0);
      send_pose(16'sd1, 16'sd0, 16'sd0, 0);
      // extreme goal and gains
      write_all(16'sh8000, 16'sh7fff, 16'hffff, 16'h0fff, 16'hffff, 16'hffff);
      send_pose(16'sh7fff, -16'sd32768, 16'sh7fff, 0);
      send_pose(16'sh7fff, -16'sd32768, -16'sd32768, 0);
      send_pose(-16'sd32768, 16'sh7fff, 16'sd0, 0);
      send_pose(16'sd0, 16'sd0, 16'sd0, 0);
      write_all(16'sh7fff, 16'sh8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_pose(16'sh7fff, -16'sd32768, 16'sd0, 0);
      send_pose(16'sh7fff, -16'sd32768, 16'sd5, 0);
      send_pose(-16'sd32768, 16'sh7fff, -16'sd32768, 0);
      send_pose(16'sd0, 16'sd0, 16'sd100, 0);
   endtask

   task automatic test_random_phase(int n, int idle_pct);
      logic signed [15:0] px, py, hd;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < 60) begin
            px = goal_x + 16'($signed($urandom_range(0, 64)) - 32);
            py = goal_y + 16'($signed($urandom_range(0, 64)) - 32);
            hd = 16'($signed($urandom_range(0, 16384)) - 8192);
         end else begin
            px = 16'($urandom);
            py = 16'($urandom);
            hd = 16'($urandom);
         end
         send_pose(px, py, hd, idle_pct);
      end
   endtask

   task automatic test_random_configs(int idle_pct);
      for (int p = 0; p < 4; p++) begin
         write_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   $urandom_range(0, 1) ? 16'($urandom_range(0, 64)) : 16'($urandom),
                   $urandom_range(0, 1) ? 16'($urandom_range(0, 2048)) : 16'($urandom));
         test_random_phase(80, idle_pct);
      end
   endtask

   initial begin
      goal_x = '0;
      goal_y = '0;
      k_lin = 12'd256;
      k_ang = 12'd1536;
      tol_lin = 16'd3;
      tol_ang = 16'd1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_configs(11);
      test_random_configs(48);
      test_random_configs(0);
      write_all(16'h0000, 16'h0000, 16'd256, 16'd1536, 16'd3, 16'd1);
      test_random_phase(60, 0);
      drain();
      $display("Covered %0d pose transactions, %0d results checked, %0d flagged arrived.",
               n_accepted, n_checked, n_arrived);
      $display("Register sets included reset, extreme and random values; %0d mismatches.",
               n_errors);
      if (n_errors == 0 && command_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Simulation FAILED");
      $finish;
   end
endmodule
